/* src/phmc_pkg.sv */
// Shared types and constants for the perfect-hash multiplier checker.
package phmc_pkg;

  localparam int WORD_W            = 64;
  localparam int CNT_W             = 7;   // holds a popcount of 0..64
  localparam int EPOCH_W           = 8;   // tag width of the seen-key map
  localparam int MAX_MASK_BITS_DEF = 12;

  typedef struct packed {
    logic [WORD_W-1:0] random_a;
    logic [WORD_W-1:0] random_b;
    logic [WORD_W-1:0] random_c;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] candidate_multiplier;
    logic              accepted;
    logic              mask_too_wide;
  } out_item_t;

  // Request into the shared multiplier.
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } mul_req_t;

  // Response from the shared multiplier.
  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] product;
  } mul_rsp_t;

endpackage

/* src/phmc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module phmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/phmc_mul.sv */
// Iterative 64x64 multiplier (low 64 bits) built on one shared 32x32 multiplier.
module phmc_mul
  import phmc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int HALF_W = WORD_W / 2;

  // partial product order: low*low, low(a)*high(b), high(a)*low(b)
  localparam logic [1:0] STEP_LL = 2'd0;
  localparam logic [1:0] STEP_LH = 2'd1;
  localparam logic [1:0] STEP_HL = 2'd2;

  logic [WORD_W-1:0] a_r, b_r;
  logic [1:0]        step_r;
  logic              run_r;
  logic [WORD_W-1:0] pp_r;
  logic [1:0]        pp_sel_r;
  logic              pp_vld_r;
  logic [WORD_W-1:0] acc_r;
  logic              done_r;

  logic [HALF_W-1:0] op_a, op_b;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] addend;

  // operand select for the shared multiplier
  always_comb begin
    case (step_r)
      STEP_LL: begin
        op_a = a_r[HALF_W-1:0];
        op_b = b_r[HALF_W-1:0];
      end
      STEP_LH: begin
        op_a = a_r[HALF_W-1:0];
        op_b = b_r[WORD_W-1:HALF_W];
      end
      STEP_HL: begin
        op_a = a_r[WORD_W-1:HALF_W];
        op_b = b_r[HALF_W-1:0];
      end
      default: begin
        op_a = a_r[HALF_W-1:0];
        op_b = b_r[HALF_W-1:0];
      end
    endcase
  end

  assign prod = op_a * op_b;

  // cross terms only contribute their low half, shifted up
  assign addend = (pp_sel_r == STEP_LL) ? pp_r : {pp_r[HALF_W-1:0], {HALF_W{1'b0}}};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= 1'b0;
      pp_vld_r <= 1'b0;
      done_r   <= 1'b0;
      step_r   <= STEP_LL;
    end else begin
      pp_vld_r <= run_r;
      done_r   <= pp_vld_r && (pp_sel_r == STEP_HL);
      if (req.start) begin
        run_r  <= 1'b1;
        step_r <= STEP_LL;
      end else if (run_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == STEP_HL) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    pp_r     <= prod;
    pp_sel_r <= step_r;
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
    end else if (pp_vld_r) begin
      acc_r <= acc_r + addend;
    end
  end

  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

`ifndef SYNTHESIS
  // a result is reported exactly once per multiply
  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("multiplier done held for more than one cycle");

  // no new request while a multiply is still running
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> !req.start)
    else $error("multiplier restarted while busy");

  // done follows each request once all three partial products are summed
  a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> ##4 done_r)
    else $error("multiplier done not on schedule");
`endif

endmodule

/* src/perfect_hash_multiplier_checker_core.sv */
// Perfect-hash multiplier checker: top-level sequencer, seen-key map and shared multiplier.
// An empty or too-wide mask is answered straight after the popcount; otherwise the 2^n
// mask subsets (n = mask popcount) are hashed in turn, rejected candidates finishing at
// the first repeated key. Each subset is one multiply on the shared 32x32 multiplier (three passes).
// One item at a time; busy stays high until the result strobe (through any clearing pass
// it starts). Every 255th keyed candidate and every reset start a clearing pass over the whole map.
// Reset is synchronous, active low; the result strobe cannot be stalled.
module perfect_hash_multiplier_checker_core
  import phmc_pkg::*;
#(
  parameter int MAX_MASK_BITS = MAX_MASK_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [WORD_W-1:0] cfg_data,
  output logic              out_valid,
  output out_item_t         out_data
);

  localparam int ADDR_W  = MAX_MASK_BITS;
  localparam int DEPTH   = 2 ** MAX_MASK_BITS;
  localparam int CHUNK   = 8;
  localparam int PC_W    = $clog2(WORD_W / CHUNK);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_CNT,
    S_EVAL,
    S_MUL_GO,
    S_MUL_WAIT,
    S_CHK
  } state_t;

  state_t            state_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic [WORD_W-1:0] mask_r;
  logic [WORD_W-1:0] mask_cur_r;
  logic [WORD_W-1:0] mask_sh_r;
  logic [PC_W-1:0]   pc_step_r;
  logic [CNT_W-1:0]  n_r;
  logic [WORD_W-1:0] cand_r;
  logic [WORD_W-1:0] sub_r;
  logic [ADDR_W-1:0] key_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  mul_req_t           mul_req;
  mul_rsp_t           mul_rsp;
  logic [CNT_W-1:0]   shamt;
  logic [WORD_W-1:0]  key_full;
  logic [ADDR_W-1:0]  key_idx;
  logic [WORD_W-1:0]  sub_nxt;
  logic               ram_wr_en;
  logic [ADDR_W-1:0]  ram_wr_addr;
  logic [EPOCH_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [EPOCH_W-1:0] ram_rd_data;
  logic               key_hit;
  logic               chk_finish;

  function automatic logic [3:0] popcount8(input logic [CHUNK-1:0] v);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < CHUNK; i++) begin
      c = c + 4'(v[i]);
    end
    return c;
  endfunction

  // shared multiplier: subset times candidate
  assign mul_req.start = (state_r == S_MUL_GO);
  assign mul_req.a     = sub_r;
  assign mul_req.b     = cand_r;

  phmc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // key = top n bits of the product
  assign shamt    = CNT_W'(WORD_W) - n_r;
  assign key_full = mul_rsp.product >> shamt;
  assign key_idx  = key_full[ADDR_W-1:0];

  // next subset of the mask (carry-rippler)
  assign sub_nxt = (sub_r - mask_cur_r) & mask_cur_r;

  // seen-key map access: clearing pass or marking a fresh key
  assign key_hit    = (ram_rd_data == epoch_r);
  assign chk_finish = key_hit || (sub_nxt == '0);
  assign ram_rd_en  = (state_r == S_MUL_WAIT) && mul_rsp.done;

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = key_r;
    ram_wr_data = epoch_r;
    if (state_r == S_CLR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_cnt_r;
      ram_wr_data = '0;
    end else if ((state_r == S_CHK) && !key_hit) begin
      ram_wr_en = 1'b1;
    end
  end

  phmc_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (DEPTH)
  ) u_seen_map (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (key_idx),
    .rd_data (ram_rd_data)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      epoch_r     <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        mask_r <= cfg_data;
      end
      unique case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (&clr_cnt_r) begin
            epoch_r <= EPOCH_W'(1);
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cand_r     <= in_data.random_a & in_data.random_b & in_data.random_c;
            mask_cur_r <= mask_r;
            mask_sh_r  <= mask_r;
            n_r        <= '0;
            pc_step_r  <= '0;
            state_r    <= S_CNT;
          end
        end
        S_CNT: begin
          n_r       <= n_r + CNT_W'(popcount8(mask_sh_r[CHUNK-1:0]));
          mask_sh_r <= mask_sh_r >> CHUNK;
          pc_step_r <= pc_step_r + 1'b1;
          if (&pc_step_r) begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (n_r > CNT_W'(MAX_MASK_BITS)) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{candidate_multiplier: cand_r, accepted: 1'b0,
                             mask_too_wide: 1'b1};
            state_r     <= S_IDLE;
          end else if (n_r == '0) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{candidate_multiplier: cand_r, accepted: 1'b1,
                             mask_too_wide: 1'b0};
            state_r     <= S_IDLE;
          end else begin
            sub_r   <= '0;
            state_r <= S_MUL_GO;
          end
        end
        S_MUL_GO: begin
          state_r <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (mul_rsp.done) begin
            key_r   <= key_idx;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (chk_finish) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{candidate_multiplier: cand_r, accepted: !key_hit,
                             mask_too_wide: 1'b0};
            // fresh tag for the next candidate; wrap forces a clearing pass
            if (&epoch_r) begin
              clr_cnt_r <= '0;
              state_r   <= S_CLR;
            end else begin
              epoch_r <= epoch_r + 1'b1;
              state_r <= S_IDLE;
            end
          end else begin
            sub_r   <= sub_nxt;
            state_r <= S_MUL_GO;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // one result per transaction, never back to back
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe on consecutive cycles");

  // a too-wide mask never reports acceptance
  a_wide_rejects: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.accepted && out_data_r.mask_too_wide))
    else $error("too-wide mask reported as accepted");

  // a cleared map entry (tag zero) must never match the live tag
  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> (epoch_r != '0))
    else $error("key check with the cleared tag");

  // an accepted transaction keeps the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("not busy after accepting a transaction");
`endif

endmodule
